FILE: rtl/core/text_glyph_cell_generator_macros.svh
// assertion macros for the text glyph cell generator checker
`ifndef TEXT_GLYPH_CELL_GENERATOR_MACROS_SVH
`define TEXT_GLYPH_CELL_GENERATOR_MACROS_SVH

// clocked check, switched off while reset is asserted
`define TGCG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds across reset
`define TGCG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/tgcg_pkg.sv
// shared constants, font tables, load bundle and helpers of the glyph cell generator
`timescale 1ns / 1ps

package tgcg_pkg;

  localparam int GLYPH_ROWS    = 7;
  localparam int GLYPH_COLS    = 5;
  localparam int GLYPH_BITS    = GLYPH_ROWS * GLYPH_COLS;
  localparam int PEN_ADVANCE   = 12;
  localparam int BASELINE_LIFT = 14;

  typedef logic [GLYPH_BITS-1:0] glyph_t;

  // bundle handed from the pen front end to the bit walker
  typedef struct packed {
    logic               load;
    glyph_t             pattern;
    logic signed [15:0] base_x;
    logic [14:0]        base_y;
  } load_t;

  // rows top first, each row with its leftmost column as msb
  localparam glyph_t DIGIT_ROM [10] = '{
    {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e},
    {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e},
    {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f},
    {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e},
    {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02},
    {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e},
    {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e},
    {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e},
    {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e}
  };

  localparam glyph_t LETTER_ROM [26] = '{
    {5'h04, 5'h0a, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11},
    {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e},
    {5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e},
    {5'h1c, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1c},
    {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f},
    {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10},
    {5'h0e, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f},
    {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11},
    {5'h0e, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e},
    {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0c},
    {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
    {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f},
    {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
    {5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11},
    {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e},
    {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10},
    {5'h0e, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0d},
    {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11},
    {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e},
    {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
    {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e},
    {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h04},
    {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0a},
    {5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11},
    {5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04},
    {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f}
  };

  localparam glyph_t QUERY_GLYPH  = {5'h1f, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
  // punctuation drawn on the same grid: a dot low in the middle, a bar across row three
  localparam glyph_t PERIOD_GLYPH = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04};
  localparam glyph_t MINUS_GLYPH  = {5'h00, 5'h00, 5'h00, 5'h1e, 5'h00, 5'h00, 5'h00};
  localparam glyph_t SPACE_GLYPH  = '0;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_PERIOD = 8'h2e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_GAP   = CH_LOWER_A - CH_UPPER_A;

  // bitmap for one byte, lower case folded to upper case
  function automatic glyph_t glyph_bits(input logic [7:0] ch);
    logic [7:0] up;
    logic [7:0] rel;
    glyph_t     g;
    up = ch;
    if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      up = ch - CASE_GAP;
    end
    rel = '0;
    if (up >= CH_ZERO && up <= CH_NINE) begin
      rel = up - CH_ZERO;
      g   = DIGIT_ROM[rel[3:0]];
    end else if (up >= CH_UPPER_A && up <= CH_UPPER_Z) begin
      rel = up - CH_UPPER_A;
      g   = LETTER_ROM[rel[4:0]];
    end else if (up == CH_SPACE) begin
      g = SPACE_GLYPH;
    end else if (up == CH_PERIOD) begin
      g = PERIOD_GLYPH;
    end else if (up == CH_MINUS) begin
      g = MINUS_GLYPH;
    end else begin
      g = QUERY_GLYPH;
    end
    return g;
  endfunction

  // signed 16-bit coordinate plus a small offset, clipped at the top of the range
  function automatic logic signed [15:0] sat_add(input logic signed [15:0] base,
                                                 input logic [3:0] off);
    logic [16:0] sum;
    sum = {base[15], base} + {13'd0, off};
    return (!sum[16] && sum[15]) ? 16'sh7fff : $signed(sum[15:0]);
  endfunction

endpackage

FILE: rtl/core/tgcg_if.sv
// valid/ready channels carrying characters in and cells out
`timescale 1ns / 1ps

interface tgcg_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         character;
  logic               start_req;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;

  modport source (output valid, character, start_req, start_x, start_y, input ready);
  modport sink   (input valid, character, start_req, start_x, start_y, output ready);
endinterface

interface tgcg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cell_x;
  logic [14:0]        cell_y;
  logic               last_cell;

  modport source (output valid, cell_x, cell_y, last_cell, input ready);
  modport sink   (input valid, cell_x, cell_y, last_cell, output ready);
endinterface

FILE: rtl/core/tgcg_pen.sv
// pen position registers and glyph lookup for each accepted character
`timescale 1ns / 1ps

module tgcg_pen (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          character,
  input  logic                start_req,
  input  logic signed [15:0]  start_x,
  input  logic signed [15:0]  start_y,
  output tgcg_pkg::load_t     load
);

  logic signed [15:0] pen_x_r, pen_x_nxt;
  logic [14:0]        pen_y_r, pen_y_nxt;
  logic [16:0]        lifted;
  logic signed [15:0] base_x;
  logic [14:0]        base_y;

  // start loads the pen, baseline lifted and clipped at the top edge
  always_comb begin
    lifted = {start_y[15], start_y} - 17'(tgcg_pkg::BASELINE_LIFT);
    if (start_req) begin
      base_x = start_x;
      base_y = lifted[16] ? 15'd0 : lifted[14:0];
    end else begin
      base_x = pen_x_r;
      base_y = pen_y_r;
    end
  end

  // pen steps one character pitch after each item
  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    if (accept) begin
      pen_x_nxt = tgcg_pkg::sat_add(base_x, 4'(tgcg_pkg::PEN_ADVANCE));
      pen_y_nxt = base_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
    end
  end

  assign load.load    = accept;
  assign load.pattern = tgcg_pkg::glyph_bits(character);
  assign load.base_x  = base_x;
  assign load.base_y  = base_y;

endmodule

FILE: rtl/core/tgcg_walker.sv
// shifts the bitmap one bit a cycle unless stalled and registers a cell per set bit
`timescale 1ns / 1ps

module tgcg_walker (
  input  logic               clk,
  input  logic               rst_n,
  input  tgcg_pkg::load_t    load,
  output logic               idle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_cell_x,
  output logic [14:0]        out_cell_y,
  output logic               out_last_cell
);

  localparam int TOP = tgcg_pkg::GLYPH_BITS - 1;

  tgcg_pkg::glyph_t   pattern_r, pattern_nxt;
  logic [2:0]         col_r, col_nxt;
  logic [2:0]         row_r, row_nxt;
  logic signed [15:0] base_x_r;
  logic [14:0]        base_y_r;
  logic               valid_r, valid_nxt;
  logic signed [15:0] cell_x_r;
  logic [14:0]        cell_y_r;
  logic               last_r;
  logic               step;
  logic               emit;

  assign idle = (pattern_r == '0);
  assign step = !idle && (!valid_r || out_ready);
  assign emit = step && pattern_r[TOP];

  // bitmap shift and column/row position
  always_comb begin
    pattern_nxt = pattern_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    if (load.load) begin
      pattern_nxt = load.pattern;
      col_nxt     = '0;
      row_nxt     = '0;
    end else if (step) begin
      pattern_nxt = {pattern_r[TOP-1:0], 1'b0};
      if (col_r == 3'(tgcg_pkg::GLYPH_COLS - 1)) begin
        col_nxt = '0;
        row_nxt = row_r + 3'd1;
      end else begin
        col_nxt = col_r + 3'd1;
      end
    end
  end

  // output register holds a cell until taken
  always_comb begin
    valid_nxt = valid_r;
    if (emit) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      col_r     <= '0;
      row_r     <= '0;
      valid_r   <= 1'b0;
    end else begin
      pattern_r <= pattern_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      valid_r   <= valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load.load) begin
      base_x_r <= load.base_x;
      base_y_r <= load.base_y;
    end
    if (emit) begin
      cell_x_r <= tgcg_pkg::sat_add(base_x_r, {col_r, 1'b0});
      cell_y_r <= base_y_r + {11'd0, row_r, 1'b0};
      last_r   <= (pattern_r[TOP-1:0] == '0);
    end
  end

  assign out_valid     = valid_r;
  assign out_cell_x    = cell_x_r;
  assign out_cell_y    = cell_y_r;
  assign out_last_cell = last_r;

endmodule

FILE: rtl/core/text_glyph_cell_generator.sv
// top level of the 5x7 text glyph cell generator
//
//  channel  dir  payload                                   handshake
//  in_ch    in   character, start_req, start_x, start_y    valid/ready
//  out_ch   out  cell_x, cell_y, last_cell                 valid/ready
//
// a character is taken, then its bitmap is walked bit by bit up to its last set bit;
// a space has no set bit and leaves the walker idle at once.
// the walk ends when the bitmap shift register in the walker empties, so glyphs
// with blank lower rows finish sooner.
// a stalled output holds the walk; the next item is taken while the last cell waits.
// reset is synchronous and clears the pen to the origin and empties the walker.
`timescale 1ns / 1ps

module text_glyph_cell_generator (
  input  logic      clk,
  input  logic      rst_n,
  tgcg_in_if.sink   in_ch,
  tgcg_out_if.source out_ch
);

  tgcg_pkg::load_t load;
  logic            idle;
  logic            accept;

  assign in_ch.ready = idle;
  assign accept      = in_ch.valid && idle;

  // pen and glyph lookup
  tgcg_pen u_pen (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .character (in_ch.character),
    .start_req (in_ch.start_req),
    .start_x   (in_ch.start_x),
    .start_y   (in_ch.start_y),
    .load      (load)
  );

  // bit walker and output register
  tgcg_walker u_walker (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .idle          (idle),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_cell_x    (out_ch.cell_x),
    .out_cell_y    (out_ch.cell_y),
    .out_last_cell (out_ch.last_cell)
  );

endmodule

FILE: rtl/core/tgcg_checker.sv
// port-level checks on the glyph cell generator, bound to the top level
`timescale 1ns / 1ps
`include "text_glyph_cell_generator_macros.svh"

module tgcg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_character,
  input logic       out_valid,
  input logic       out_ready
);

  // a stalled cell stays offered
  `TGCG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "cell dropped while stalled")

  // any character but a space keeps the walker busy in the next cycle
  `TGCG_ASSERT(a_busy_after_glyph, in_valid && in_ready && in_character != tgcg_pkg::CH_SPACE |=> !in_ready, "input taken again before glyph walked")

  // a new cell only comes from a walk in progress
  `TGCG_ASSERT(a_cell_from_walk, $rose(out_valid) |-> !$past(in_ready), "cell offered with walker idle")

  // reset leaves no cell on offer
  `TGCG_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid, "cell offered after reset")

endmodule

bind text_glyph_cell_generator tgcg_checker u_tgcg_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_character (in_ch.character),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready)
);

FILE: tb/sv/tb_text_glyph_cell_generator.sv
// self-checking testbench for the 5x7 text glyph cell generator
`timescale 1ns / 1ps

module tb_text_glyph_cell_generator;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int DIR_ROWS = 25;
  localparam int QUERY_IDX = 36;

  typedef struct packed {
    logic signed [15:0] x;
    logic [14:0]        y;
    logic               last;
  } cell_t;

  // one directed row: typed_cnt -1 means the pen model supplies the cells
  typedef struct packed {
    logic [7:0]         ch;
    logic               st;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [7:0]  typed_cnt;
    logic signed [15:0] tx;
    logic [14:0]        ty;
  } dir_row_t;

  logic clk;
  logic rst_n;

  tgcg_in_if  in_ch ();
  tgcg_out_if out_ch ();

  text_glyph_cell_generator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // pen copy and the cells still owed by the block
  int    pen_x;
  int    pen_y;
  cell_t pending_cells[$];

  // typed expectation that travels with the item on the input channel
  int                 typed_cnt;
  logic signed [15:0] typed_x;
  logic [14:0]        typed_y;

  int src_idle_pct;
  int snk_idle_pct;
  int fail_count;
  int items_taken;
  int cells_checked;
  int starts_taken;
  int stall_cycles;

  dir_row_t dir_tbl [DIR_ROWS] = '{
    '{8'h2e, 1'b0, 16'sh0000, 16'sh0000, 8'sd1, 16'sd4, 15'd12},
    '{8'h20, 1'b0, 16'sh1234, 16'sh4321, 8'sd0, 16'sd0, 15'd0},
    '{8'h2d, 1'b1, 16'sh8000, 16'sh8000, -8'sd1, 16'sd0, 15'd0},
    '{8'h2e, 1'b1, 16'sh7fff, 16'sh7fff, 8'sd1, 16'sh7fff, 15'd32765},
    '{8'h41, 1'b0, 16'sh0000, 16'sh0000, -8'sd1, 16'sd0, 15'd0},
    '{8'h00, 1'b0, 16'shffff, 16'shffff, -8'sd1, 16'sd0, 15'd0},
    '{8'hff, 1'b1, 16'sd32760, 16'sd14, -8'sd1, 16'sd0, 15'd0},
    '{8'h2e, 1'b1, 16'sd100, 16'sd13, 8'sd1, 16'sd104, 15'd12},
    '{8'h20, 1'b1, 16'sd0, 16'sd0, 8'sd0, 16'sd0, 15'd0},
    '{8'h2d, 1'b0, 16'sd0, 16'sd0, -8'sd1, 16'sd0, 15'd0},
    '{8'h30, 1'b0, 16'sd0, 16'sd0, -8'sd1, 16'sd0, 15'd0},
    '{8'h39, 1'b0, 16'sd0, 16'sd0, -8'sd1, 16'sd0, 15'd0},
    '{8'h61, 1'b0, 16'sd0, 16'sd0, -8'sd1, 16'sd0, 15'd0},
    '{8'h7a, 1'b0, 16'sd0, 16'sd0, -8'sd1, 16'sd0, 15'd0},
    '{8'h5a, 1'b0, 16'sd0, 16'sd0, -8'sd1, 16'sd0, 15'd0},
    '{8'h40, 1'b0, 16'sd0, 16'sd0, -8'sd1, 16'sd0, 15'd0},
    '{8'h5b, 1'b0, 16'sd0, 16'sd0, -8'sd1, 16'sd0, 15'd0},
    '{8'h60, 1'b0, 16'sd0, 16'sd0, -8'sd1, 16'sd0, 15'd0},
    '{8'h7b, 1'b0, 16'sd0, 16'sd0, -8'sd1, 16'sd0, 15'd0},
    '{8'h2f, 1'b0, 16'sd0, 16'sd0, -8'sd1, 16'sd0, 15'd0},
    '{8'h3a, 1'b0, 16'sd0, 16'sd0, -8'sd1, 16'sd0, 15'd0},
    '{8'h4d, 1'b1, 16'sd32761, 16'sd20, -8'sd1, 16'sd0, 15'd0},
    '{8'h38, 1'b0, 16'sd0, 16'sd0, -8'sd1, 16'sd0, 15'd0},
    '{8'h80, 1'b1, 16'shffff, 16'shffff, -8'sd1, 16'sd0, 15'd0},
    '{8'h57, 1'b0, 16'sd0, 16'sd0, -8'sd1, 16'sd0, 15'd0}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // font: digits 0..9, letters 10..35, question mark 36; rows top first, msb leftmost
  function automatic logic [34:0] font_pattern(input int idx);
    logic [34:0] p;
    case (idx)
      0:  p = {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
      1:  p = {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
      2:  p = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
      3:  p = {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e};
      4:  p = {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
      5:  p = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e};
      6:  p = {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
      7:  p = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      8:  p = {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
      9:  p = {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e};
      10: p = {5'h04, 5'h0a, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11};
      11: p = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e};
      12: p = {5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e};
      13: p = {5'h1c, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1c};
      14: p = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f};
      15: p = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10};
      16: p = {5'h0e, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f};
      17: p = {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
      18: p = {5'h0e, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
      19: p = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0c};
      20: p = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      21: p = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f};
      22: p = {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      23: p = {5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11};
      24: p = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
      25: p = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
      26: p = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0d};
      27: p = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
      28: p = {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
      29: p = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      30: p = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
      31: p = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h04};
      32: p = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0a};
      33: p = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11};
      34: p = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04};
      35: p = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f};
      default: p = {5'h1f, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
    endcase
    return p;
  endfunction

  // cell at pen plus offset, x clipped at the top of the signed range
  function automatic cell_t pen_cell(input int dx, input int dy);
    cell_t c;
    int    cx;
    cx = pen_x + dx;
    if (cx > 32767) begin
      cx = 32767;
    end
    c.x    = cx[15:0];
    c.y    = 15'(pen_y + dy);
    c.last = 1'b0;
    return c;
  endfunction

  // pen update and the cells one character paints
  function automatic void paint_char(input logic [7:0] ch, input logic st,
                                     input logic signed [15:0] sx,
                                     input logic signed [15:0] sy,
                                     ref cell_t cells[$]);
    int          y_load;
    int          idx;
    logic [7:0]  up;
    logic [34:0] pat;
    cells.delete();
    if (st) begin
      y_load = int'(sy) - 14;
      pen_x  = int'(sx);
      pen_y  = (y_load < 0) ? 0 : y_load;
    end
    up = ch;
    if (ch >= 8'h61 && ch <= 8'h7a) begin
      up = ch - 8'h20;
    end
    idx = -1;
    if (up >= 8'h30 && up <= 8'h39) begin
      idx = int'(up) - 8'h30;
    end else if (up >= 8'h41 && up <= 8'h5a) begin
      idx = int'(up) - 8'h41 + 10;
    end else if (up == 8'h2e) begin
      cells.push_back(pen_cell(4, 12));
    end else if (up == 8'h2d) begin
      for (int i = 0; i < 4; i++) begin
        cells.push_back(pen_cell(2 * i, 6));
      end
    end else if (up != 8'h20) begin
      idx = QUERY_IDX;
    end
    if (idx >= 0) begin
      pat = font_pattern(idx);
      for (int b = 34; b >= 0; b--) begin
        if (pat[b]) begin
          cells.push_back(pen_cell(2 * ((34 - b) % 5), 2 * ((34 - b) / 5)));
        end
      end
    end
    if (cells.size() > 0) begin
      cells[cells.size() - 1].last = 1'b1;
    end
    pen_x = (pen_x + 12 > 32767) ? 32767 : pen_x + 12;
  endfunction

  // input and output monitor: predicts on each accepted item, checks each cell
  always @(posedge clk) begin
    cell_t fresh[$];
    cell_t want;
    cell_t typed;
    logic  moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        items_taken++;
        if (in_ch.start_req) begin
          starts_taken++;
        end
        paint_char(in_ch.character, in_ch.start_req, in_ch.start_x, in_ch.start_y, fresh);
        if (typed_cnt < 0) begin
          foreach (fresh[i]) begin
            pending_cells.push_back(fresh[i]);
          end
        end else if (typed_cnt == 1) begin
          typed.x    = typed_x;
          typed.y    = typed_y;
          typed.last = 1'b1;
          pending_cells.push_back(typed);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (pending_cells.size() == 0) begin
          $error("cell (%0d,%0d) with no cell expected", $signed(out_ch.cell_x),
                 out_ch.cell_y);
          fail_count++;
        end else begin
          want = pending_cells.pop_front();
          cells_checked++;
          if (out_ch.cell_x !== want.x) begin
            $error("cell_x expected %0d actual %0d", want.x, $signed(out_ch.cell_x));
            fail_count++;
          end
          if (out_ch.cell_y !== want.y) begin
            $error("cell_y expected %0d actual %0d", want.y, out_ch.cell_y);
            fail_count++;
          end
          if (out_ch.last_cell !== want.last) begin
            $error("last_cell expected %0d actual %0d", want.last, out_ch.last_cell);
            fail_count++;
          end
        end
      end
      // watchdog on cycles with work owed but nothing moving
      if (moved) begin
        stall_cycles = 0;
      end else if (pending_cells.size() != 0 || in_ch.valid) begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // receiver with random back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // offer one item, with random gaps before it, and wait until it is taken
  task automatic send_char(input logic [7:0] ch, input logic st,
                           input logic signed [15:0] sx, input logic signed [15:0] sy,
                           input int t_cnt, input logic signed [15:0] t_x,
                           input logic [14:0] t_y);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.character <= ch;
    in_ch.start_req <= st;
    in_ch.start_x   <= sx;
    in_ch.start_y   <= sy;
    typed_cnt       <= t_cnt;
    typed_x         <= t_x;
    typed_y         <= t_y;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
  endtask

  // hold the sender off until every owed cell has come out
  task automatic wait_cells_out();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_cells.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // mostly printable text, with punctuation, spaces and raw bytes mixed in
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = 8'(8'h41 + $urandom_range(0, 25));
      3, 4:    c = 8'(8'h61 + $urandom_range(0, 25));
      5:       c = 8'(8'h30 + $urandom_range(0, 9));
      6:       c = 8'h20;
      7:       c = $urandom_range(0, 1) ? 8'h2e : 8'h2d;
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // coordinates leaning towards the clip points
  function automatic logic signed [15:0] pick_coord();
    logic signed [15:0] v;
    case ($urandom_range(0, 5))
      0:       v = 16'sh7fff - 16'($urandom_range(0, 40));
      1:       v = 16'sh8000 + 16'($urandom_range(0, 3));
      2:       v = 16'($urandom_range(0, 30));
      default: v = 16'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  // stimulus
  initial begin
    logic st;
    fail_count    = 0;
    items_taken   = 0;
    cells_checked = 0;
    starts_taken  = 0;
    stall_cycles  = 0;
    pen_x         = 0;
    pen_y         = 0;
    src_idle_pct  = 10;
    snk_idle_pct  = 66;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.character <= '0;
    in_ch.start_req <= 1'b0;
    in_ch.start_x   <= '0;
    in_ch.start_y   <= '0;
    typed_cnt       <= -1;
    typed_x         <= '0;
    typed_y         <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows: reset state, extremes, every glyph class
    foreach (dir_tbl[i]) begin
      send_char(dir_tbl[i].ch, dir_tbl[i].st, dir_tbl[i].sx, dir_tbl[i].sy,
                int'(dir_tbl[i].typed_cnt), dir_tbl[i].tx, dir_tbl[i].ty);
    end
    wait_cells_out();

    // random text under three back-pressure mixes
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 10;
          snk_idle_pct = 66;
        end
        1: begin
          src_idle_pct = 66;
          snk_idle_pct = 10;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        st = ($urandom_range(0, 7) == 0);
        send_char(pick_char(), st, pick_coord(), pick_coord(), -1, '0, '0);
      end
      wait_cells_out();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d characters (%0d pen loads) and %0d cells,", items_taken,
             starts_taken, cells_checked);
    $display("across saturating and clamped pens and three back-pressure mixes");
    if (fail_count == 0 && pending_cells.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
